/* hw/rtl/wheel_angle_sensor_filter_defines.svh */
// ---------------------------------------------------------------------------
// wheel angle sensor filter assertion macros
// shared property wrappers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef WHEEL_ANGLE_SENSOR_FILTER_DEFINES_SVH
`define WHEEL_ANGLE_SENSOR_FILTER_DEFINES_SVH

// property checked outside reset only
`define WASF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define WASF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/wasf_pkg.sv */
// ---------------------------------------------------------------------------
// wasf_pkg
// types, constants and register map of the wheel angle sensor filter
// ---------------------------------------------------------------------------
package wasf_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ANGLE_W  = 24;
    localparam int unsigned ALPHA_W  = 16;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned CPD_W    = 10;
    localparam int unsigned AVG_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 40;

    // calibration constants
    localparam logic [SAMPLE_W-1:0] ZERO_POINT = 16'd6805;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 16'd32768;
    localparam logic [ANGLE_W-1:0]  ANGLE_MAX  = 24'd8388607;

    // register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd32768;
    localparam logic [CPD_W-1:0]    CPD_RST    = 10'd100;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd0;

    // queue depth between front and back
    localparam int unsigned FIFO_DEPTH_DEF = 2;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ALPHA      = 3'd0,
        REG_INVERT_DIRECTION  = 3'd1,
        REG_WIRELESS_MODE     = 3'd2,
        REG_STEER_OFFSET      = 3'd3,
        REG_COUNTS_PER_DEGREE = 3'd4
    } cfg_index_t;

    // live configuration
    typedef struct packed {
        logic [ALPHA_W-1:0]         filter_alpha;
        logic                       invert_direction;
        logic                       wireless_mode;
        logic signed [OFFSET_W-1:0] steer_offset;
        logic [CPD_W-1:0]           counts_per_degree;
    } cfg_t;

    // work item handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0]        raw;
        logic signed [SAMPLE_W-1:0] pos;
        logic                       inv;
        logic                       bypass;
    } entry_t;

endpackage

/* hw/rtl/wasf_front.sv */
// ---------------------------------------------------------------------------
// wasf_front
// accepts samples, updates the moving average and forms the position
// ---------------------------------------------------------------------------
module wasf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wasf_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wasf_pkg::SAMPLE_W-1:0]     s_tdata,    // raw_reading
    output logic                              push,
    output wasf_pkg::entry_t                  push_entry,
    input  logic                              fifo_full
);
    import wasf_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_UPD  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic                    bypass_reg;
    logic                    primed_reg;
    logic [2*SAMPLE_W-1:0]   prod_new_reg;
    logic [ALPHA_W+AVG_W-1:0] prod_old_reg;

    logic [ALPHA_W-1:0]      alpha_sat;
    logic [ALPHA_W-1:0]      alpha_rest;
    logic [ALPHA_W+AVG_W:0]  acc;
    logic [SAMPLE_W-1:0]     avg_int;
    logic [SAMPLE_W-1:0]     pos_base;

    // weight saturation
    assign alpha_sat  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign alpha_rest = ALPHA_ONE - alpha_sat;

    // weighted sum of the registered products
    assign acc = {1'b0, prod_new_reg, {SAMPLE_W{1'b0}}} + {1'b0, prod_old_reg};

    // position from the integer part of the average, wraps to 16 bits
    assign avg_int  = avg_reg[AVG_W-1 -: SAMPLE_W];
    assign pos_base = {1'b0, avg_int[SAMPLE_W-1:1]} - ZERO_POINT;

    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !fifo_full;

    always_comb
    begin
        push_entry.raw    = avg_int;
        push_entry.pos    = cfg.invert_direction ? $signed(pos_base - cfg.steer_offset)
                                                 : $signed(pos_base + cfg.steer_offset);
        push_entry.inv    = cfg.invert_direction;
        push_entry.bypass = bypass_reg;
    end

    // sequencer and average update
    always_comb
    begin
        state_next = state_reg;
        avg_next   = avg_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cfg.wireless_mode ? F_PUSH : F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_UPD;
            end
            F_UPD:
            begin
                avg_next   = primed_reg ? acc[ALPHA_W+AVG_W-2 -: AVG_W]
                                        : {sample_reg, {SAMPLE_W{1'b0}}};
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            avg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            avg_reg   <= avg_next;
        end
    end

    // capture the beat and form the products
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && s_tvalid)
        begin
            sample_reg <= s_tdata;
            bypass_reg <= cfg.wireless_mode;
        end
        if (state_reg == F_MUL)
        begin
            primed_reg   <= (avg_reg != '0);
            prod_new_reg <= alpha_sat * sample_reg;
            prod_old_reg <= alpha_rest * avg_reg;
        end
    end

endmodule

/* hw/rtl/wasf_fifo.sv */
// ---------------------------------------------------------------------------
// wasf_fifo
// short queue of work items between front and back
// ---------------------------------------------------------------------------
module wasf_fifo #(
    parameter int unsigned DEPTH = wasf_pkg::FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wasf_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output wasf_pkg::entry_t pop_entry,
    output logic             empty
);
    import wasf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/wasf_back.sv */
// ---------------------------------------------------------------------------
// wasf_back
// bit-serial angle divider with sign handling and output register
// ---------------------------------------------------------------------------
module wasf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wasf_pkg::cfg_t                    cfg,
    input  logic                              empty,
    output logic                              pop,
    input  wasf_pkg::entry_t                  pop_entry,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wasf_pkg::OUT_DATA_W-1:0]   m_tdata,    // filtered_raw, angle_q8
    output logic                              m_tuser     // bypassed
);
    import wasf_pkg::*;

    localparam int unsigned STEP_W = $clog2(ANGLE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ANGLE_W - 1);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [ANGLE_W-1:0]   quo_reg;
    logic [CPD_W-1:0]     rem_reg;
    logic [CPD_W-1:0]     div_reg;
    logic                 neg_reg;
    logic                 bypass_reg;
    logic [SAMPLE_W-1:0]  raw_reg;

    logic                 m_tvalid_reg;
    logic [SAMPLE_W-1:0]  out_raw_reg;
    logic [ANGLE_W-1:0]   out_angle_reg;
    logic                 out_bypass_reg;

    logic [CPD_W:0]       rem_try;
    logic                 rem_ge;
    logic [SAMPLE_W-1:0]  mag;
    logic                 out_free;
    logic [ANGLE_W-1:0]   angle;

    // magnitude of the position
    assign mag = pop_entry.pos[SAMPLE_W-1] ? SAMPLE_W'(-pop_entry.pos)
                                           : SAMPLE_W'(pop_entry.pos);

    // one restoring step
    assign rem_try = {rem_reg, quo_reg[ANGLE_W-1]};
    assign rem_ge  = (rem_try >= {1'b0, div_reg});

    // signed result, saturated on the positive side
    assign angle = neg_reg ? (~quo_reg + 1'b1)
                           : ((quo_reg > ANGLE_MAX) ? ANGLE_MAX : quo_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = (state_reg == B_IDLE) && !empty;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_angle_reg, out_raw_reg};
    assign m_tuser  = out_bypass_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = pop_entry.bypass ? B_OUT : B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    raw_reg    <= pop_entry.raw;
                    bypass_reg <= pop_entry.bypass;
                    neg_reg    <= !pop_entry.bypass
                                  && (pop_entry.pos[SAMPLE_W-1] ^ pop_entry.inv);
                    quo_reg    <= pop_entry.bypass ? '0 : {mag, 8'd0};
                    rem_reg    <= '0;
                    step_reg   <= '0;
                    div_reg    <= (cfg.counts_per_degree == '0) ? CPD_W'(1)
                                                                : cfg.counts_per_degree;
                end
            end
            B_DIV:
            begin
                rem_reg  <= rem_ge ? CPD_W'(rem_try - {1'b0, div_reg}) : rem_try[CPD_W-1:0];
                quo_reg  <= {quo_reg[ANGLE_W-2:0], rem_ge};
                step_reg <= step_reg + 1'b1;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_raw_reg    <= raw_reg;
                    out_angle_reg  <= angle;
                    out_bypass_reg <= bypass_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/wheel_angle_sensor_filter.sv */
// data path: front end (capture, multiply, update, push), queue, 24 divide steps, output register
// the back end pops a sample, divides it and hands it to the output register before it pops the next
// wireless-mode samples skip the average update and the divider
// reset: asynchronous active low, state and config registers return to defaults and the average
//   is cleared to zero, so the first nonzero sample loads directly
// ---------------------------------------------------------------------------
// wheel_angle_sensor_filter
// moving-average filter and linear calibration of wheel angle sensor samples
// ---------------------------------------------------------------------------
module wheel_angle_sensor_filter #(
    parameter int unsigned FIFO_DEPTH = wasf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wasf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wasf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wasf_pkg::SAMPLE_W-1:0]       s_tdata,    // [15:0] raw_reading
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wasf_pkg::OUT_DATA_W-1:0]     m_tdata,    // [15:0] filtered_raw, [39:16] angle_q8
    output logic                                m_tuser     // [0] bypassed
);
    import wasf_pkg::*;

    cfg_t   cfg_reg;
    logic   push, fifo_full, pop, fifo_empty;
    entry_t push_entry, pop_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha      <= ALPHA_RST;
            cfg_reg.invert_direction  <= 1'b0;
            cfg_reg.wireless_mode     <= 1'b0;
            cfg_reg.steer_offset      <= OFFSET_RST;
            cfg_reg.counts_per_degree <= CPD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_ALPHA:      cfg_reg.filter_alpha      <= cfg_data[ALPHA_W-1:0];
                REG_INVERT_DIRECTION:  cfg_reg.invert_direction  <= cfg_data[0];
                REG_WIRELESS_MODE:     cfg_reg.wireless_mode     <= cfg_data[0];
                REG_STEER_OFFSET:      cfg_reg.steer_offset      <= cfg_data[OFFSET_W-1:0];
                REG_COUNTS_PER_DEGREE: cfg_reg.counts_per_degree <= cfg_data[CPD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // filter front end
    wasf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .fifo_full  (fifo_full)
    );

    // decoupling queue
    wasf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (fifo_empty)
    );

    // divider back end
    wasf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (fifo_empty),
        .pop       (pop),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* hw/rtl/wasf_checker.sv */
// ---------------------------------------------------------------------------
// wasf_checker
// port-level checks of the wheel angle sensor filter
// ---------------------------------------------------------------------------
`include "wheel_angle_sensor_filter_defines.svh"

module wasf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [wasf_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tuser
);
    import wasf_pkg::*;

    // no result beat on the edge after a reset edge
    `WASF_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |=> !m_tvalid, "result valid during reset")

    // a held result beat stays valid
    `WASF_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")

    // a bypassed beat always reports a zero angle
    `WASF_ASSERT(a_bypass_zero, m_tvalid && m_tuser |-> (m_tdata[OUT_DATA_W-1:SAMPLE_W] == '0), "bypass with nonzero angle")

    // a sample is never taken in the cycle right after one was taken
    `WASF_ASSERT(a_input_spacing, s_tvalid && s_tready |=> !s_tready, "back to back sample accept")

endmodule

bind wheel_angle_sensor_filter wasf_checker u_wasf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
